### design/stp_pkg.sv
`default_nettype none
package stp_pkg;

  // Sizes of the stores
  localparam int SECTIONS      = 8;
  localparam int HISTORY_DEPTH = 64;
  localparam int ELAPSED_WIDTH = 16;

  // Field widths
  localparam int REQ_W   = 3;
  localparam int SEC_W   = 3;
  localparam int SLOT_W  = 6;
  localparam int STAMP_W = 32;
  localparam int FPS_W   = 8;

  localparam int SIDX_W  = $clog2(SECTIONS);
  localparam int HIST_AW = $clog2(HISTORY_DEPTH);

  localparam logic [ELAPSED_WIDTH-1:0] ELAPSED_MAX = '1;
  localparam logic [FPS_W-1:0]         TALLY_MAX   = '1;
  localparam logic [FPS_W-1:0]         TPS_RESET   = FPS_W'(60);

  // Register map (index taken from paddr[2])
  localparam logic REG_TPS = 1'b0;

  // Request codes; codes six and seven act as a read
  typedef enum logic [REQ_W-1:0] {
    REQ_TICK        = 3'd0,
    REQ_FRAME_BEGIN = 3'd1,
    REQ_FRAME_END   = 3'd2,
    REQ_SEC_BEGIN   = 3'd3,
    REQ_SEC_END     = 3'd4,
    REQ_READ        = 3'd5
  } req_t;

  // Frame length pushed into the history ring
  typedef struct packed {
    logic                     en;
    logic [ELAPSED_WIDTH-1:0] len;
  } hist_wr_t;

  // Ticks since a stamp, modulo 2^32, clamped to the elapsed width
  function automatic logic [ELAPSED_WIDTH-1:0] interval_sat(
    input logic [STAMP_W-1:0] now,
    input logic [STAMP_W-1:0] stamp
  );
    logic [STAMP_W-1:0] d;
    d = now - stamp;
    if (d > STAMP_W'(ELAPSED_MAX))
      interval_sat = ELAPSED_MAX;
    else
      interval_sat = d[ELAPSED_WIDTH-1:0];
  endfunction

  // Saturating accumulate
  function automatic logic [ELAPSED_WIDTH-1:0] sat_add(
    input logic [ELAPSED_WIDTH-1:0] a,
    input logic [ELAPSED_WIDTH-1:0] b
  );
    logic [ELAPSED_WIDTH:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s[ELAPSED_WIDTH])
      sat_add = ELAPSED_MAX;
    else
      sat_add = s[ELAPSED_WIDTH-1:0];
  endfunction

endpackage
`default_nettype wire

### design/stp_sections.sv
`default_nettype none
module stp_sections (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               accept,
  input  wire stp_pkg::req_t                      req,
  input  wire logic [stp_pkg::SEC_W-1:0]          sec,
  input  wire logic [stp_pkg::STAMP_W-1:0]        tick_count,
  output stp_pkg::hist_wr_t                       hist_wr,
  output logic [stp_pkg::ELAPSED_WIDTH-1:0]       elapsed_nxt,
  output logic [stp_pkg::ELAPSED_WIDTH-1:0]       peak_nxt,
  output logic                                    running_nxt,
  output logic [stp_pkg::ELAPSED_WIDTH-1:0]       frame_len_nxt,
  output logic [stp_pkg::ELAPSED_WIDTH-1:0]       frame_peak_nxt
);
  import stp_pkg::*;

  logic [STAMP_W-1:0]       start_r [SECTIONS];
  logic [STAMP_W-1:0]       start_nxt [SECTIONS];
  logic [ELAPSED_WIDTH-1:0] acc_r [SECTIONS];
  logic [ELAPSED_WIDTH-1:0] acc_nxt [SECTIONS];
  logic [ELAPSED_WIDTH-1:0] pk_r [SECTIONS];
  logic [ELAPSED_WIDTH-1:0] pk_nxt [SECTIONS];
  logic [SECTIONS-1:0]      run_r;
  logic [SECTIONS-1:0]      run_nxt;
  logic [ELAPSED_WIDTH-1:0] frame_len_r;
  logic [ELAPSED_WIDTH-1:0] frame_peak_r;

  logic                     sec_ok;
  logic [SIDX_W-1:0]        sidx;
  logic [STAMP_W-1:0]       stamp_sel;
  logic [ELAPSED_WIDTH-1:0] len;

  assign sec_ok = (32'(sec) < SECTIONS);
  assign sidx   = SIDX_W'(sec);

  // One interval unit: frame end measures section 0, section end the addressed one
  assign stamp_sel = (req == REQ_FRAME_END) ? start_r[0] : start_r[sidx];
  assign len       = interval_sat(tick_count, stamp_sel);

  // Next state of the section file
  always_comb begin
    start_nxt      = start_r;
    acc_nxt        = acc_r;
    pk_nxt         = pk_r;
    run_nxt        = run_r;
    frame_len_nxt  = frame_len_r;
    frame_peak_nxt = frame_peak_r;
    hist_wr        = '0;
    if (accept) begin
      case (req)
        REQ_FRAME_BEGIN: begin
          start_nxt[0] = tick_count;
          run_nxt[0]   = 1'b1;
          for (int i = 1; i < SECTIONS; i++) acc_nxt[i] = '0;
        end
        REQ_FRAME_END: begin
          acc_nxt[0]    = len;
          run_nxt[0]    = 1'b0;
          if (len > pk_r[0]) pk_nxt[0] = len;
          frame_len_nxt = len;
          if (len > frame_peak_r) frame_peak_nxt = len;
          hist_wr.en    = 1'b1;
          hist_wr.len   = len;
        end
        REQ_SEC_BEGIN: begin
          if (sec_ok) begin
            start_nxt[sidx] = tick_count;
            run_nxt[sidx]   = 1'b1;
          end
        end
        REQ_SEC_END: begin
          // ending an idle section is ignored
          if (sec_ok && run_r[sidx]) begin
            acc_nxt[sidx] = sat_add(acc_r[sidx], len);
            run_nxt[sidx] = 1'b0;
            if (len > pk_r[sidx]) pk_nxt[sidx] = len;
          end
        end
        default: ;
      endcase
    end
  end

  // Addressed section as it stands after the request
  assign elapsed_nxt = sec_ok ? acc_nxt[sidx] : '0;
  assign peak_nxt    = sec_ok ? pk_nxt[sidx]  : '0;
  assign running_nxt = sec_ok ? run_nxt[sidx] : 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < SECTIONS; i++) begin
        start_r[i] <= '0;
        acc_r[i]   <= '0;
        pk_r[i]    <= '0;
      end
      run_r        <= '0;
      frame_len_r  <= '0;
      frame_peak_r <= '0;
    end else begin
      start_r      <= start_nxt;
      acc_r        <= acc_nxt;
      pk_r         <= pk_nxt;
      run_r        <= run_nxt;
      frame_len_r  <= frame_len_nxt;
      frame_peak_r <= frame_peak_nxt;
    end
  end

endmodule
`default_nettype wire

### design/stp_rate.sv
`default_nettype none
module stp_rate (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          accept,
  input  wire stp_pkg::req_t                 req,
  input  wire logic [stp_pkg::FPS_W-1:0]     tps,
  output logic [stp_pkg::STAMP_W-1:0]        tick_cur,
  output logic [stp_pkg::STAMP_W-1:0]        tick_nxt,
  output logic [stp_pkg::FPS_W-1:0]          fps_nxt
);
  import stp_pkg::*;

  logic [STAMP_W-1:0] tick_r;
  logic [FPS_W-1:0]   window_r, window_nxt;
  logic [FPS_W-1:0]   tally_r, tally_nxt;
  logic [FPS_W-1:0]   fps_r;
  logic [FPS_W-1:0]   window_inc;

  assign window_inc = window_r + FPS_W'(1);

  // Tick counter, measurement window and frame tally
  always_comb begin
    tick_nxt   = tick_r;
    window_nxt = window_r;
    tally_nxt  = tally_r;
    fps_nxt    = fps_r;
    if (accept) begin
      case (req)
        REQ_TICK: begin
          tick_nxt = tick_r + STAMP_W'(1);
          if (window_inc >= tps) begin
            fps_nxt    = tally_r;
            tally_nxt  = '0;
            window_nxt = '0;
          end else begin
            window_nxt = window_inc;
          end
        end
        REQ_FRAME_END: begin
          if (tally_r != TALLY_MAX) tally_nxt = tally_r + FPS_W'(1);
        end
        default: ;
      endcase
    end
  end

  assign tick_cur = tick_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_r   <= '0;
      window_r <= '0;
      tally_r  <= '0;
      fps_r    <= '0;
    end else begin
      tick_r   <= tick_nxt;
      window_r <= window_nxt;
      tally_r  <= tally_nxt;
      fps_r    <= fps_nxt;
    end
  end

endmodule
`default_nettype wire

### design/stp_history.sv
`default_nettype none
module stp_history (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               accept,
  input  wire stp_pkg::hist_wr_t                  hist_wr,
  input  wire logic [stp_pkg::SLOT_W-1:0]         rd_slot,
  output logic [stp_pkg::ELAPSED_WIDTH-1:0]       hist_value
);
  import stp_pkg::*;

  logic [ELAPSED_WIDTH-1:0] mem [HISTORY_DEPTH];
  logic [HISTORY_DEPTH-1:0] valid_r;
  logic [HIST_AW-1:0]       head_r;
  logic [HIST_AW-1:0]       head_nxt;
  logic [HIST_AW-1:0]       rd_idx;
  logic                     slot_ok;
  logic                     hit;

  logic [ELAPSED_WIDTH-1:0] rd_q_r;
  logic [ELAPSED_WIDTH-1:0] byp_data_r;
  logic                     byp_r;
  logic                     rd_valid_r;
  logic                     slot_ok_r;

  assign rd_idx   = HIST_AW'(rd_slot);
  assign slot_ok  = (32'(rd_slot) < HISTORY_DEPTH);
  assign hit      = hist_wr.en && (head_r == rd_idx);
  assign head_nxt = (32'(head_r) == HISTORY_DEPTH - 1) ? '0 : head_r + HIST_AW'(1);

  // Ring storage: write at the head, registered read at the requested slot
  always_ff @(posedge clk) begin
    if (hist_wr.en) mem[head_r] <= hist_wr.len;
    if (accept) begin
      rd_q_r     <= mem[rd_idx];
      byp_data_r <= hist_wr.len;
    end
  end

  // Head pointer, written-entry flags and read qualifiers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r    <= '0;
      head_r     <= '0;
      byp_r      <= 1'b0;
      rd_valid_r <= 1'b0;
      slot_ok_r  <= 1'b0;
    end else begin
      if (hist_wr.en) begin
        valid_r[head_r] <= 1'b1;
        head_r          <= head_nxt;
      end
      if (accept) begin
        byp_r      <= hit;
        rd_valid_r <= valid_r[rd_idx];
        slot_ok_r  <= slot_ok;
      end
    end
  end

  // A slot written by this same request shows the new length
  always_comb begin
    if (!slot_ok_r)
      hist_value = '0;
    else if (byp_r)
      hist_value = byp_data_r;
    else if (rd_valid_r)
      hist_value = rd_q_r;
    else
      hist_value = '0;
  end

endmodule
`default_nettype wire

### design/section_timing_profiler.sv
// Section timing profiler.
// Input stream (in_*): one request per beat: tick, frame begin, frame end,
// section begin, section end or read, with a section index and a history
// slot. Every accepted request yields exactly one result beat (out_*) that
// reflects the state after that request: addressed section's elapsed, peak
// and running flag, last and longest frame length, frames per second, the
// chosen history entry and the tick counter.
// The result is loaded into the output register at the accepting edge and
// is offered on out_* from the next cycle. Throughput is one request per
// cycle while the receiver keeps out_tready high, limited by the registered
// update of the section file and the one-write/one-read history ring port.
// The output register decouples the sides: a new request is taken while a
// result is waiting as long as out_tready is high in the same cycle; when the
// receiver stalls, the result holds and in_tready drops.
// Reset (rst_n low, synchronous) clears all counters, sections and the
// history ring (through per-entry written flags, no clearing pass) and sets
// ticks_per_second to 60. The APB register at address 0 holds
// ticks_per_second; write it only while the block is idle.
`default_nettype none
module section_timing_profiler (
  input  wire logic         clk,
  input  wire logic         rst_n,
  // in_tdata: req_type[2:0], section[5:3], history_slot[11:6], zero[15:12]
  input  wire logic         in_tvalid,
  output logic              in_tready,
  input  wire logic [15:0]  in_tdata,
  // out_tdata: section_elapsed[15:0], section_peak[31:16], section_running[32],
  //   last_frame_ticks[48:33], longest_frame_ticks[64:49],
  //   frames_per_second[72:65], history_value[88:73], tick_count[120:89],
  //   zero[127:121]
  output logic              out_tvalid,
  input  wire logic         out_tready,
  output logic [127:0]      out_tdata,
  input  wire logic         cfg_psel,
  input  wire logic         cfg_penable,
  input  wire logic         cfg_pwrite,
  input  wire logic [2:0]   cfg_paddr,
  input  wire logic [31:0]  cfg_pwdata,
  output logic [31:0]       cfg_prdata,
  output logic              cfg_pready
);
  import stp_pkg::*;

  logic                     accept;
  req_t                     req;
  logic [SEC_W-1:0]         sec;
  logic [SLOT_W-1:0]        slot;
  logic [FPS_W-1:0]         tps_r;
  logic                     out_valid_r;

  hist_wr_t                 hist_wr;
  logic [ELAPSED_WIDTH-1:0] elapsed_nxt, peak_nxt, frame_len_nxt, frame_peak_nxt;
  logic                     running_nxt;
  logic [STAMP_W-1:0]       tick_cur, tick_nxt;
  logic [FPS_W-1:0]         fps_nxt;
  logic [ELAPSED_WIDTH-1:0] hist_value;

  logic [ELAPSED_WIDTH-1:0] elapsed_r, peak_r, last_r, longest_r;
  logic                     running_r;
  logic [FPS_W-1:0]         fps_r;
  logic [STAMP_W-1:0]       tick_r;

  // Request unpacking and handshake
  assign req       = req_t'(in_tdata[2:0]);
  assign sec       = in_tdata[5:3];
  assign slot      = in_tdata[11:6];
  assign in_tready = !out_valid_r || out_tready;
  assign accept    = in_tvalid && in_tready;

  // Configuration register
  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr[2] == REG_TPS) ? {24'b0, tps_r} : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tps_r <= TPS_RESET;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
                 (cfg_paddr[2] == REG_TPS)) begin
      tps_r <= cfg_pwdata[FPS_W-1:0];
    end
  end

  stp_sections u_sections (
    .clk            (clk),
    .rst_n          (rst_n),
    .accept         (accept),
    .req            (req),
    .sec            (sec),
    .tick_count     (tick_cur),
    .hist_wr        (hist_wr),
    .elapsed_nxt    (elapsed_nxt),
    .peak_nxt       (peak_nxt),
    .running_nxt    (running_nxt),
    .frame_len_nxt  (frame_len_nxt),
    .frame_peak_nxt (frame_peak_nxt)
  );

  stp_rate u_rate (
    .clk      (clk),
    .rst_n    (rst_n),
    .accept   (accept),
    .req      (req),
    .tps      (tps_r),
    .tick_cur (tick_cur),
    .tick_nxt (tick_nxt),
    .fps_nxt  (fps_nxt)
  );

  stp_history u_history (
    .clk        (clk),
    .rst_n      (rst_n),
    .accept     (accept),
    .hist_wr    (hist_wr),
    .rd_slot    (slot),
    .hist_value (hist_value)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      elapsed_r <= elapsed_nxt;
      peak_r    <= peak_nxt;
      running_r <= running_nxt;
      last_r    <= frame_len_nxt;
      longest_r <= frame_peak_nxt;
      fps_r     <= fps_nxt;
      tick_r    <= tick_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'b0, tick_r, hist_value, fps_r, longest_r, last_r,
                       running_r, peak_r, elapsed_r};

  // Checks
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> out_tvalid)
    else $error("accepted request produced no result");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid_r |-> in_tready)
    else $error("input stalled with empty result register");

  a_longest_frame: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (longest_r >= last_r))
    else $error("longest frame below last frame");

  a_tick_step: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (req == REQ_TICK)) |=> (tick_cur == $past(tick_cur) + 32'd1))
    else $error("tick counter did not advance on tick");

endmodule
`default_nettype wire
